>>> rtl/fitting_alignment_traceback_defines.svh
// Assertion macros shared by the fitting alignment checker.
`ifndef FITTING_ALIGNMENT_TRACEBACK_DEFINES_SVH
`define FITTING_ALIGNMENT_TRACEBACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fitting alignment check failed");

// Next-cycle implication, disabled during reset.
`define FAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fitting alignment check failed");

`endif

>>> rtl/fat_pkg.sv
// Shared constants and types for the fitting alignment block.
package fat_pkg;

    localparam int SYM_W       = 8;
    localparam int OP_W        = 2;
    localparam int SCORE_OUT_W = 7;
    localparam int STATUS_W    = 2;
    localparam int ITEM_W      = 18;

    // command opcodes
    localparam logic [OP_W-1:0] OP_LOAD_PAT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_REF = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

    // traceback directions
    localparam logic [1:0] DIR_DIAG = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // token that walks the cell chain with each pattern row
    typedef struct packed {
        logic valid;
        logic last;
    } fat_tok_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic ref_we;
    } fat_ctl_t;

endpackage

>>> rtl/fat_if.sv
// Command and result channel interfaces.
interface fat_cmd_if;
    import fat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       opcode;
    logic [SYM_W-1:0]      symbol;
    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface fat_res_if;
    import fat_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [SYM_W-1:0]              ref_symbol;
    logic                          ref_gap;
    logic [SYM_W-1:0]              pat_symbol;
    logic                          pat_gap;
    logic signed [SCORE_OUT_W-1:0] best_score;
    logic [STATUS_W-1:0]           status;
    logic                          last;
    modport source (output valid, output ref_symbol, output ref_gap, output pat_symbol,
                    output pat_gap, output best_score, output status, output last,
                    input ready);
    modport sink   (input valid, input ref_symbol, input ref_gap, input pat_symbol,
                    input pat_gap, input best_score, input status, input last,
                    output ready);
endinterface

>>> rtl/fat_cell.sv
// One reference column of the scoring chain: score, direction store, best tracking.
module fat_cell
    import fat_pkg::*;
#(
    parameter int COL = 1,
    parameter int MAX_PATTERN = 32,
    parameter int SW = 8,
    parameter int PW = 6,
    parameter int CW = 6,
    parameter int AW = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fat_ctl_t             ctl,
    input  logic [CW-1:0]        ref_idx,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [CW-1:0]        ref_len,
    input  logic [AW-1:0]        rd_addr,
    input  fat_tok_t             in_tok,
    input  logic [SYM_W-1:0]     in_pchar,
    input  logic [PW-1:0]        in_row,
    input  logic signed [SW-1:0] in_left,
    input  logic signed [SW-1:0] in_diag,
    input  logic signed [SW-1:0] in_best,
    input  logic [CW-1:0]        in_bestj,
    output fat_tok_t             out_tok,
    output logic [SYM_W-1:0]     out_pchar,
    output logic [PW-1:0]        out_row,
    output logic signed [SW-1:0] out_left,
    output logic signed [SW-1:0] out_diag,
    output logic signed [SW-1:0] out_best,
    output logic [CW-1:0]        out_bestj,
    output logic [SYM_W-1:0]     ref_char,
    output logic [1:0]           dir_rd
);

    localparam logic [CW-1:0]        COL_IDX = CW'(COL);
    localparam logic [CW-1:0]        COL_M1  = CW'(COL - 1);
    localparam logic signed [SW-1:0] ONE     = SW'(1);

    logic [SYM_W-1:0]     ref_reg;
    logic signed [SW-1:0] score_reg;
    logic [1:0]           dir_mem [MAX_PATTERN];
    logic [1:0]           dir_rd_reg;
    fat_tok_t             tok_reg;
    logic [SYM_W-1:0]     pchar_reg;
    logic [PW-1:0]        row_reg;
    logic signed [SW-1:0] snew_reg;
    logic signed [SW-1:0] sold_reg;
    logic signed [SW-1:0] best_reg;
    logic [CW-1:0]        bestj_reg;

    logic signed [SW-1:0] dg;
    logic signed [SW-1:0] up;
    logic signed [SW-1:0] lf;
    logic signed [SW-1:0] s;
    logic [1:0]           d;
    logic                 take;
    logic [PW-1:0]        row_m1;

    // cell recurrence: max of diagonal, up and left
    always_comb
    begin
        dg = (in_pchar == ref_reg) ? in_diag + ONE : in_diag - ONE;
        up = score_reg - ONE;
        lf = in_left - ONE;
        s  = dg;
        if (up > s)
        begin
            s = up;
        end
        if (lf > s)
        begin
            s = lf;
        end
        if (dg == s)
        begin
            d = DIR_DIAG;
        end
        else if (up == s)
        begin
            d = DIR_UP;
        end
        else
        begin
            d = DIR_LEFT;
        end
        take   = in_tok.last && (COL_IDX <= ref_len) && (s > in_best);
        row_m1 = in_row - PW'(1);
    end

    // token handoff to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= in_tok;
        end
    end

    // column storage and payload handoff
    always_ff @(posedge clk)
    begin
        if (ctl.ref_we && ref_idx == COL_M1)
        begin
            ref_reg <= symbol;
        end
        if (ctl.clear)
        begin
            score_reg <= '0;
        end
        else if (in_tok.valid)
        begin
            score_reg <= s;
        end
        if (in_tok.valid)
        begin
            dir_mem[row_m1[AW-1:0]] <= d;
        end
        dir_rd_reg <= dir_mem[rd_addr];
        pchar_reg  <= in_pchar;
        row_reg    <= in_row;
        snew_reg   <= s;
        sold_reg   <= score_reg;
        best_reg   <= take ? s : in_best;
        bestj_reg  <= take ? COL_IDX : in_bestj;
    end

    assign out_tok   = tok_reg;
    assign out_pchar = pchar_reg;
    assign out_row   = row_reg;
    assign out_left  = snew_reg;
    assign out_diag  = sold_reg;
    assign out_best  = best_reg;
    assign out_bestj = bestj_reg;
    assign ref_char  = ref_reg;
    assign dir_rd    = dir_rd_reg;

endmodule

>>> rtl/fitting_alignment_traceback.sv
// Fitting alignment top level: loader, cell chain, traceback and result emitter.
//
// cmd channel: opcode 0 loads a pattern byte, 1 a reference byte, 2 runs the
// alignment; opcode 3 is taken and ignored. Loads are accepted back to back;
// bytes beyond capacity are dropped and flagged.
// res channel: one transaction per aligned column in forward order, with last
// set on the final one; an empty pattern gives one status-2 transaction.
// A run fills the cell chain one pattern row per cycle; traceback starts once
// the last row leaves the chain. Each traceback step reads the direction and
// pattern symbol through registers (S_TRACE_RD) and then evaluates (S_TRACE_EV);
// each result passes through S_EMIT_RD, S_EMIT_LD and S_EMIT_OUT and waits in
// S_EMIT_OUT while the receiver holds ready low.
// The cmd channel is not ready from the run transaction until the last result
// is taken.
// Reset clears the lengths, the overflow flag, the state and the output valid;
// stores are undefined until loaded. After a run both lengths and the overflow
// flag return to zero.
module fitting_alignment_traceback
    import fat_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_REFERENCE = 32
)
(
    input logic       clk,
    input logic       rst_n,
    fat_cmd_if.sink   cmd,
    fat_res_if.source res
);

    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam int CW = $clog2(MAX_REFERENCE + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RW = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
    localparam int SW = PW + 2;
    localparam int PATH_LEN = MAX_PATTERN + MAX_REFERENCE;
    localparam int BW = $clog2(PATH_LEN);
    localparam int KW = $clog2(PATH_LEN + 1);
    localparam logic signed [SW-1:0] ONE = SW'(1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FILL     = 8'b0000_0010,
        S_DRAIN    = 8'b0000_0100,
        S_TRACE_RD = 8'b0000_1000,
        S_TRACE_EV = 8'b0001_0000,
        S_EMIT_RD  = 8'b0010_0000,
        S_EMIT_LD  = 8'b0100_0000,
        S_EMIT_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [PW-1:0] pat_len_reg, pat_len_next;
    logic [CW-1:0] ref_len_reg, ref_len_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] feed_reg, feed_next;
    fat_tok_t      inj_tok_reg;
    logic [PW-1:0] inj_row_reg;
    logic signed [SW-1:0] best_reg, best_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [PW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;

    logic [SYM_W-1:0]  pat_mem [MAX_PATTERN];
    logic [SYM_W-1:0]  pat_rd_reg;
    logic [ITEM_W-1:0] pb_mem [PATH_LEN];
    logic [ITEM_W-1:0] pb_rd_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [ITEM_W-1:0]           out_item_reg, out_item_next;
    logic signed [SCORE_OUT_W-1:0] out_best_reg, out_best_next;
    logic [STATUS_W-1:0]         out_status_reg, out_status_next;
    logic                        out_last_reg, out_last_next;

    logic          cmd_acc;
    logic          pat_we;
    fat_ctl_t      ctl;
    logic [PW-1:0] i_m1;
    logic [CW-1:0] j_m1;
    logic [AW-1:0] pat_addr;
    logic          pb_we;
    logic [ITEM_W-1:0] item;
    logic [KW-1:0] pb_rd_idx;
    logic [1:0]    d_sel;
    logic [SYM_W-1:0] ref_sel;
    logic          jz;

    fat_tok_t             tok_w   [MAX_REFERENCE + 1];
    logic [SYM_W-1:0]     pchar_w [MAX_REFERENCE + 1];
    logic [PW-1:0]        row_w   [MAX_REFERENCE + 1];
    logic signed [SW-1:0] snew_w  [MAX_REFERENCE + 1];
    logic signed [SW-1:0] sold_w  [MAX_REFERENCE + 1];
    logic signed [SW-1:0] best_w  [MAX_REFERENCE + 1];
    logic [CW-1:0]        bestj_w [MAX_REFERENCE + 1];
    logic [SYM_W-1:0]     ref_bus [MAX_REFERENCE];
    logic [1:0]           dir_bus [MAX_REFERENCE];

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign i_m1      = i_reg - PW'(1);
    assign j_m1      = j_reg - CW'(1);
    assign jz        = (j_reg == '0);
    assign pat_addr  = (state_reg == S_FILL) ? feed_reg[AW-1:0] : i_m1[AW-1:0];
    assign pb_rd_idx = cnt_reg - KW'(1) - k_reg;
    assign d_sel     = dir_bus[j_m1[RW-1:0]];
    assign ref_sel   = ref_bus[j_m1[RW-1:0]];

    // column 0 source: score -row, diagonal -(row-1), best starts at -n
    assign tok_w[0]   = inj_tok_reg;
    assign pchar_w[0] = pat_rd_reg;
    assign row_w[0]   = inj_row_reg;
    assign snew_w[0]  = -$signed(SW'(inj_row_reg));
    assign sold_w[0]  = snew_w[0] + ONE;
    assign best_w[0]  = -$signed(SW'(pat_len_reg));
    assign bestj_w[0] = '0;

    // one cell per reference column
    for (genvar c = 1; c <= MAX_REFERENCE; c++)
    begin : g_cell
        fat_cell #(
            .COL(c),
            .MAX_PATTERN(MAX_PATTERN),
            .SW(SW),
            .PW(PW),
            .CW(CW),
            .AW(AW)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctl(ctl),
            .ref_idx(ref_len_reg),
            .symbol(cmd.symbol),
            .ref_len(ref_len_reg),
            .rd_addr(i_m1[AW-1:0]),
            .in_tok(tok_w[c-1]),
            .in_pchar(pchar_w[c-1]),
            .in_row(row_w[c-1]),
            .in_left(snew_w[c-1]),
            .in_diag(sold_w[c-1]),
            .in_best(best_w[c-1]),
            .in_bestj(bestj_w[c-1]),
            .out_tok(tok_w[c]),
            .out_pchar(pchar_w[c]),
            .out_row(row_w[c]),
            .out_left(snew_w[c]),
            .out_diag(sold_w[c]),
            .out_best(best_w[c]),
            .out_bestj(bestj_w[c]),
            .ref_char(ref_bus[c-1]),
            .dir_rd(dir_bus[c-1])
        );
    end

    // traceback step
    always_comb
    begin
        item   = '0;
        i_next = i_reg;
        j_next = j_reg;
        if (d_sel == DIR_DIAG && !jz)
        begin
            item   = {1'b0, pat_rd_reg, 1'b0, ref_sel};
            i_next = i_m1;
            j_next = j_m1;
        end
        else if (d_sel != DIR_LEFT || jz)
        begin
            item   = {1'b0, pat_rd_reg, 1'b1, {SYM_W{1'b0}}};
            i_next = i_m1;
        end
        else
        begin
            item   = {1'b1, {SYM_W{1'b0}}, 1'b0, ref_sel};
            j_next = j_m1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        pat_len_next    = pat_len_reg;
        ref_len_next    = ref_len_reg;
        ovf_next        = ovf_reg;
        feed_next       = feed_reg;
        best_next       = best_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        out_best_next   = out_best_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        pat_we          = 1'b0;
        ctl             = '0;
        pb_we           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.opcode)
                        OP_LOAD_PAT:
                        begin
                            if (pat_len_reg < PW'(MAX_PATTERN))
                            begin
                                pat_we       = 1'b1;
                                pat_len_next = pat_len_reg + PW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_REF:
                        begin
                            if (ref_len_reg < CW'(MAX_REFERENCE))
                            begin
                                ctl.ref_we   = 1'b1;
                                ref_len_next = ref_len_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            status_next = ovf_reg ? ST_OVERFLOW : ST_OK;
                            if (pat_len_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_item_next   = '0;
                                out_best_next   = '0;
                                out_status_next = ST_EMPTY;
                                out_last_next   = 1'b1;
                                state_next      = S_EMIT_OUT;
                            end
                            else
                            begin
                                ctl.clear  = 1'b1;
                                feed_next  = '0;
                                state_next = S_FILL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                feed_next = feed_reg + PW'(1);
                if (feed_reg == pat_len_reg - PW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (tok_w[MAX_REFERENCE].valid && tok_w[MAX_REFERENCE].last)
                begin
                    best_next  = best_w[MAX_REFERENCE];
                    cnt_next   = '0;
                    state_next = S_TRACE_RD;
                end
            end
            S_TRACE_RD:
            begin
                state_next = S_TRACE_EV;
            end
            S_TRACE_EV:
            begin
                pb_we    = 1'b1;
                cnt_next = cnt_reg + KW'(1);
                if (i_next == '0)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_TRACE_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                out_valid_next  = 1'b1;
                out_item_next   = pb_rd_reg;
                out_best_next   = SCORE_OUT_W'(best_reg);
                out_status_next = status_reg;
                out_last_next   = (k_reg + KW'(1) == cnt_reg);
                state_next      = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + KW'(1);
                    if (out_last_reg)
                    begin
                        pat_len_next = '0;
                        ref_len_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pat_len_reg   <= '0;
            ref_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            inj_tok_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pat_len_reg       <= pat_len_next;
            ref_len_reg       <= ref_len_next;
            ovf_reg           <= ovf_next;
            inj_tok_reg.valid <= (state_reg == S_FILL);
            inj_tok_reg.last  <= (state_reg == S_FILL) && (feed_reg == pat_len_reg - PW'(1));
            out_valid_reg     <= out_valid_next;
        end
    end

    // working registers and memories
    always_ff @(posedge clk)
    begin
        feed_reg       <= feed_next;
        inj_row_reg    <= feed_reg + PW'(1);
        best_reg       <= best_next;
        status_reg     <= status_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        out_item_reg   <= out_item_next;
        out_best_reg   <= out_best_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (state_reg == S_DRAIN)
        begin
            i_reg <= pat_len_reg;
            j_reg <= bestj_w[MAX_REFERENCE];
        end
        else if (state_reg == S_TRACE_EV)
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
        if (pat_we)
        begin
            pat_mem[pat_len_reg[AW-1:0]] <= cmd.symbol;
        end
        pat_rd_reg <= pat_mem[pat_addr];
        if (pb_we)
        begin
            pb_mem[cnt_reg[BW-1:0]] <= item;
        end
        pb_rd_reg <= pb_mem[pb_rd_idx[BW-1:0]];
    end

    assign res.valid      = out_valid_reg;
    assign res.ref_symbol = out_item_reg[SYM_W-1:0];
    assign res.ref_gap    = out_item_reg[SYM_W];
    assign res.pat_symbol = out_item_reg[2*SYM_W:SYM_W+1];
    assign res.pat_gap    = out_item_reg[ITEM_W-1];
    assign res.best_score = out_best_reg;
    assign res.status     = out_status_reg;
    assign res.last       = out_last_reg;

endmodule

>>> rtl/fat_checker.sv
// Port-level checks for the fitting alignment block, bound to the top level.
`include "fitting_alignment_traceback_defines.svh"

module fat_checker
    import fat_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic [OP_W-1:0]               cmd_opcode,
    input logic                          res_valid,
    input logic [SYM_W-1:0]              res_ref_symbol,
    input logic                          res_ref_gap,
    input logic [SYM_W-1:0]              res_pat_symbol,
    input logic                          res_pat_gap,
    input logic signed [SCORE_OUT_W-1:0] res_best_score,
    input logic [STATUS_W-1:0]           res_status,
    input logic                          res_last
);

    // no command is taken while a result is pending
    `FAT_ASSERT_NOW(a_busy_while_result, clk, rst_n, res_valid, !cmd_ready)

    // a run transaction makes the block busy on the next cycle
    `FAT_ASSERT_NEXT(a_run_busy, clk, rst_n,
        cmd_valid && cmd_ready && cmd_opcode == OP_RUN, !cmd_ready)

    // a column never has gaps on both sides
    `FAT_ASSERT_NOW(a_one_gap, clk, rst_n, res_valid, !(res_ref_gap && res_pat_gap))

    // gap sides carry a zero symbol
    `FAT_ASSERT_NOW(a_gap_zero, clk, rst_n, res_valid && (res_ref_gap || res_pat_gap),
        (!res_ref_gap || res_ref_symbol == '0) && (!res_pat_gap || res_pat_symbol == '0))

    // empty-pattern result is a single all-zero last transaction
    `FAT_ASSERT_NOW(a_empty_form, clk, rst_n, res_valid && res_status == ST_EMPTY,
        res_last && res_best_score == '0 && !res_ref_gap && !res_pat_gap)

endmodule

bind fitting_alignment_traceback fat_checker u_fat_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd.valid),
    .cmd_ready(cmd.ready),
    .cmd_opcode(cmd.opcode),
    .res_valid(res.valid),
    .res_ref_symbol(res.ref_symbol),
    .res_ref_gap(res.ref_gap),
    .res_pat_symbol(res.pat_symbol),
    .res_pat_gap(res.pat_gap),
    .res_best_score(res.best_score),
    .res_status(res.status),
    .res_last(res.last)
);
